[design/json_number_lexer_defines.svh]
// Shared assertion macros for the JSON number lexer.
`ifndef JSON_NUMBER_LEXER_DEFINES_SVH
`define JSON_NUMBER_LEXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JNL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define JNL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/jnl_pkg.sv]
package jnl_pkg;

   typedef enum logic [1:0] {
      KIND_INT  = 2'd0,
      KIND_HUGE = 2'd1,
      KIND_REAL = 2'd2,
      KIND_ERR  = 2'd3
   } kind_type;

   typedef struct packed {
      logic        emit;
      kind_type    kind;
      logic [63:0] value;
      logic [15:0] length;
   } scan_result_type;

   // Largest magnitude that can still take one more decimal digit.
   localparam logic [63:0] TEN_LIMIT   = 64'h1999_9999_9999_9998;
   localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;
   localparam int unsigned HUGE_MIN_LEN = 19;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_EXP_L = 8'h65;
   localparam logic [7:0] CHAR_EXP_U = 8'h45;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

endpackage

[design/jnl_scan.sv]
module jnl_scan
   import jnl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      text_byte,
   output scan_result_type result
);

   `include "json_number_lexer_defines.svh"

   typedef enum logic [3:0] {
      PH_START = 4'd0,
      PH_MINUS = 4'd1,
      PH_ZERO  = 4'd2,
      PH_INT   = 4'd3,
      PH_HUGE  = 4'd4,
      PH_POINT = 4'd5,
      PH_FRAC  = 4'd6,
      PH_EXP   = 4'd7,
      PH_ESIGN = 4'd8,
      PH_EDIG  = 4'd9
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [63:0] magnitude_ff, magnitude_in;
   logic        negative_ff, negative_in;
   logic [15:0] count_ff, count_in;

   logic        is_digit, is_exp, is_space;
   logic [63:0] digit_val, times_ten;
   logic        clear, count_up;
   logic [15:0] count_base;

   assign is_digit  = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
   assign is_exp    = (text_byte == CHAR_EXP_L) || (text_byte == CHAR_EXP_U);
   assign is_space  = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB) ||
                      (text_byte == CHAR_LF) || (text_byte == CHAR_CR);
   assign digit_val = {60'd0, text_byte[3:0]};
   assign times_ten = (magnitude_ff << 3) + (magnitude_ff << 1) + digit_val;

   always_comb begin
      phase_in      = phase_ff;
      magnitude_in  = magnitude_ff;
      negative_in   = negative_ff;
      clear         = 1'b0;
      count_up      = 1'b1;
      count_base    = count_ff;
      result.emit   = 1'b0;
      result.kind   = KIND_ERR;
      result.value  = 64'd0;
      result.length = count_ff;

      unique case (phase_ff)
         PH_MINUS: begin
            if (text_byte == CHAR_ZERO) begin
               negative_in  = 1'b0;
               magnitude_in = 64'd0;
               phase_in     = PH_ZERO;
            end else if (is_digit) begin
               magnitude_in = digit_val;
               phase_in     = PH_INT;
            end else begin
               result.emit = 1'b1;
            end
         end
         PH_ZERO: begin
            if (text_byte == CHAR_POINT) phase_in = PH_POINT;
            else if (is_exp) phase_in = PH_EXP;
            else begin
               result.emit = 1'b1;
               result.kind = KIND_INT;
            end
         end
         PH_INT: begin
            if (is_digit) begin
               if (magnitude_ff > TEN_LIMIT) phase_in = PH_HUGE;
               else magnitude_in = times_ten;
            end else if (text_byte == CHAR_POINT) phase_in = PH_POINT;
            else if (is_exp) phase_in = PH_EXP;
            else begin
               result.emit = 1'b1;
               if (negative_ff && (magnitude_ff <= NEG_LIMIT)) begin
                  result.kind  = KIND_INT;
                  result.value = 64'd0 - magnitude_ff;
               end else if (!negative_ff && (magnitude_ff <= POS_LIMIT)) begin
                  result.kind  = KIND_INT;
                  result.value = magnitude_ff;
               end else begin
                  result.kind = KIND_HUGE;
               end
            end
         end
         PH_HUGE: begin
            if (is_digit) phase_in = PH_HUGE;
            else if (text_byte == CHAR_POINT) phase_in = PH_POINT;
            else if (is_exp) phase_in = PH_EXP;
            else begin
               result.emit = 1'b1;
               result.kind = KIND_HUGE;
            end
         end
         PH_POINT, PH_ESIGN: begin
            if (is_digit) phase_in = (phase_ff == PH_POINT) ? PH_FRAC : PH_EDIG;
            else result.emit = 1'b1;
         end
         PH_FRAC: begin
            if (is_digit) phase_in = PH_FRAC;
            else if (is_exp) phase_in = PH_EXP;
            else begin
               result.emit = 1'b1;
               result.kind = KIND_REAL;
            end
         end
         PH_EXP: begin
            if (is_digit) phase_in = PH_EDIG;
            else if ((text_byte == CHAR_PLUS) || (text_byte == CHAR_MINUS))
               phase_in = PH_ESIGN;
            else result.emit = 1'b1;
         end
         PH_EDIG: begin
            if (is_digit) phase_in = PH_EDIG;
            else begin
               result.emit = 1'b1;
               result.kind = KIND_REAL;
            end
         end
         default: begin
            // start: restart the scan from a clean slate
            magnitude_in  = 64'd0;
            negative_in   = 1'b0;
            count_base    = 16'd0;
            result.length = 16'd0;
            if (is_space) begin
               phase_in = PH_START;
               count_up = 1'b0;
            end else if (text_byte == CHAR_MINUS) begin
               negative_in = 1'b1;
               phase_in    = PH_MINUS;
            end else if (text_byte == CHAR_ZERO) begin
               phase_in = PH_ZERO;
            end else if (is_digit) begin
               magnitude_in = digit_val;
               phase_in     = PH_INT;
            end else begin
               result.emit = 1'b1;
            end
         end
      endcase

      clear = result.emit;
      if (clear) begin
         phase_in     = PH_START;
         magnitude_in = 64'd0;
         negative_in  = 1'b0;
         count_in     = 16'd0;
      end else if (count_up) begin
         count_in = (count_base == COUNT_MAX) ? count_base : count_base + 16'd1;
      end else begin
         count_in = count_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         magnitude_ff <= 64'd0;
         negative_ff  <= 1'b0;
         count_ff     <= 16'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         magnitude_ff <= magnitude_in;
         negative_ff  <= negative_in;
         count_ff     <= count_in;
      end
   end

   `JNL_ASSERT_NEXT(a_emit_restarts, step && result.emit, phase_ff == PH_START, "no restart after result")
   `JNL_ASSERT_NOW(a_start_clean, phase_ff == PH_START, (magnitude_ff == 64'd0) && (count_ff == 16'd0), "start phase not clean")
   `JNL_ASSERT_NOW(a_scan_counted, phase_ff != PH_START, count_ff != 16'd0, "scan phase with empty count")

endmodule

[design/json_number_lexer.sv]
// JSON number lexer.
// Input channel req_*: one text byte per word (req_text_byte). Leading
// whitespace is skipped; the bytes of a number are consumed silently.
// Output channel rsp_*: one word per number, issued on the first byte that
// does not continue it: kind (integer, huge integer, non-integer, syntax
// error), the signed value for integers, and the length of the number.
// The terminating byte is consumed but not rescanned as a new number.
// Throughput: one byte per cycle except while stalled. The digit accumulate
// (times ten plus digit, then a range compare) is the longest path.
// Latency: the result word is valid the cycle after its terminating byte
// is accepted, from the output register.
// Stall: while a result waits in the output register, bytes that do not
// finish a number are still taken; a byte that would finish one waits
// until rsp_ready frees the register.
// Reset: synchronous, active high; the scanner returns to its start phase
// and the output register is emptied. No clearing pass is needed.
module json_number_lexer
   import jnl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_text_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_number_kind,
   output logic signed [63:0] rsp_integer_result,
   output logic [15:0]        rsp_number_length
);

   `include "json_number_lexer_defines.svh"

   scan_result_type scan_res;
   logic            req_fire;
   logic            rsp_valid_ff;
   kind_type        kind_ff;
   logic [63:0]     value_ff;
   logic [15:0]     length_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready || !scan_res.emit;
   assign req_fire  = req_valid && req_ready;

   jnl_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step      (req_fire),
      .text_byte (req_text_byte),
      .result    (scan_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && scan_res.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the word until taken
   always_ff @(posedge clock) begin
      if (req_fire && scan_res.emit) begin
         kind_ff   <= scan_res.kind;
         value_ff  <= scan_res.value;
         length_ff <= scan_res.length;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_number_kind    = kind_ff;
   assign rsp_integer_result = value_ff;
   assign rsp_number_length  = length_ff;

   `JNL_ASSERT_NOW(a_value_only_int, rsp_valid_ff && (kind_ff != KIND_INT), value_ff == 64'd0, "nonzero value for non-integer")
   `JNL_ASSERT_NOW(a_no_overwrite, req_fire && rsp_valid_ff && !rsp_ready, !scan_res.emit, "result word overwritten")
   `JNL_ASSERT_NOW(a_huge_length, rsp_valid_ff && (kind_ff == KIND_HUGE), length_ff >= 16'(HUGE_MIN_LEN), "huge integer too short")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

localparam logic [63:0] DIGIT_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF - 64'd9) / 64'd10;
localparam logic [63:0] INT_MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;
localparam logic [63:0] INT_MIN_MAG = 64'h8000_0000_0000_0000;

typedef enum logic [3:0] {
   SCAN_START, SCAN_MINUS, SCAN_ZERO, SCAN_INT, SCAN_HUGE,
   SCAN_POINT, SCAN_FRAC, SCAN_EXP, SCAN_ESIGN, SCAN_EDIG
} scan_phase_type;

typedef struct {
   jnl_pkg::kind_type kind;
   logic [63:0]       value;
   logic [15:0]       length;
} lexed_number_type;

class number_tracker;
   scan_phase_type   phase;
   logic [63:0]      mag;
   bit               neg;
   logic [15:0]      count;
   lexed_number_type expected_numbers[$];
   int unsigned      errors;

   function new();
      errors = 0;
      restart();
   endfunction

   function void restart();
      phase = SCAN_START;
      mag   = '0;
      neg   = 1'b0;
      count = '0;
   endfunction

   function void close_number(jnl_pkg::kind_type kind, logic [63:0] value);
      lexed_number_type n;
      n.kind   = kind;
      n.value  = value;
      n.length = count;
      expected_numbers.push_back(n);
      restart();
   endfunction

   function void close_integer();
      if (neg) begin
         if (mag <= INT_MIN_MAG) close_number(jnl_pkg::KIND_INT, 64'd0 - mag);
         else close_number(jnl_pkg::KIND_HUGE, '0);
      end else if (mag <= INT_MAX_MAG) begin
         close_number(jnl_pkg::KIND_INT, mag);
      end else begin
         close_number(jnl_pkg::KIND_HUGE, '0);
      end
   endfunction

   // Advance the scanner by one accepted word.
   function void scan_byte(logic [7:0] c);
      bit             dig;
      bit             ex;
      logic [63:0]    d;
      scan_phase_type nxt;
      dig = (c >= jnl_pkg::CHAR_ZERO) && (c <= jnl_pkg::CHAR_NINE);
      ex  = (c == jnl_pkg::CHAR_EXP_L) || (c == jnl_pkg::CHAR_EXP_U);
      d   = {56'd0, c - jnl_pkg::CHAR_ZERO};
      nxt = phase;
      case (phase)
         SCAN_MINUS: begin
            if (c == jnl_pkg::CHAR_ZERO) begin
               neg = 1'b0;
               mag = '0;
               nxt = SCAN_ZERO;
            end else if (dig) begin
               mag = d;
               nxt = SCAN_INT;
            end else begin
               close_number(jnl_pkg::KIND_ERR, '0);
               return;
            end
         end
         SCAN_ZERO: begin
            if (c == jnl_pkg::CHAR_POINT) nxt = SCAN_POINT;
            else if (ex) nxt = SCAN_EXP;
            else begin
               close_number(jnl_pkg::KIND_INT, '0);
               return;
            end
         end
         SCAN_INT: begin
            if (dig) begin
               if (mag > DIGIT_LIMIT) nxt = SCAN_HUGE;
               else mag = mag * 64'd10 + d;
            end else if (c == jnl_pkg::CHAR_POINT) nxt = SCAN_POINT;
            else if (ex) nxt = SCAN_EXP;
            else begin
               close_integer();
               return;
            end
         end
         SCAN_HUGE: begin
            if (dig) nxt = SCAN_HUGE;
            else if (c == jnl_pkg::CHAR_POINT) nxt = SCAN_POINT;
            else if (ex) nxt = SCAN_EXP;
            else begin
               close_number(jnl_pkg::KIND_HUGE, '0);
               return;
            end
         end
         SCAN_POINT: begin
            if (dig) nxt = SCAN_FRAC;
            else begin
               close_number(jnl_pkg::KIND_ERR, '0);
               return;
            end
         end
         SCAN_FRAC: begin
            if (dig) nxt = SCAN_FRAC;
            else if (ex) nxt = SCAN_EXP;
            else begin
               close_number(jnl_pkg::KIND_REAL, '0);
               return;
            end
         end
         SCAN_EXP: begin
            if (dig) nxt = SCAN_EDIG;
            else if (c == jnl_pkg::CHAR_PLUS || c == jnl_pkg::CHAR_MINUS) nxt = SCAN_ESIGN;
            else begin
               close_number(jnl_pkg::KIND_ERR, '0);
               return;
            end
         end
         SCAN_ESIGN: begin
            if (dig) nxt = SCAN_EDIG;
            else begin
               close_number(jnl_pkg::KIND_ERR, '0);
               return;
            end
         end
         SCAN_EDIG: begin
            if (dig) nxt = SCAN_EDIG;
            else begin
               close_number(jnl_pkg::KIND_REAL, '0);
               return;
            end
         end
         default: begin
            // drop whitespace ahead of a number
            if (c == jnl_pkg::CHAR_SPACE || c == jnl_pkg::CHAR_TAB ||
                c == jnl_pkg::CHAR_LF || c == jnl_pkg::CHAR_CR) begin
               restart();
               return;
            end
            restart();
            if (c == jnl_pkg::CHAR_MINUS) begin
               neg = 1'b1;
               nxt = SCAN_MINUS;
            end else if (c == jnl_pkg::CHAR_ZERO) begin
               nxt = SCAN_ZERO;
            end else if (dig) begin
               mag = d;
               nxt = SCAN_INT;
            end else begin
               close_number(jnl_pkg::KIND_ERR, '0);
               return;
            end
         end
      endcase
      if (count != jnl_pkg::COUNT_MAX) count++;
      phase = nxt;
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task match_number(logic [1:0] kind, logic [63:0] value, logic [15:0] length);
      lexed_number_type want;
      if (expected_numbers.size() == 0) begin
         report($sformatf("unexpected word kind=%0d value=%0h len=%0d", kind, value, length));
         return;
      end
      want = expected_numbers.pop_front();
      if (kind !== want.kind)
         report($sformatf("kind %0d, want %0d", kind, want.kind));
      if (value !== want.value)
         report($sformatf("value %0h, want %0h", value, want.value));
      if (length !== want.length)
         report($sformatf("length %0d, want %0d", length, want.length));
   endtask

   function int pending();
      return expected_numbers.size();
   endfunction
endclass

module tb_top;
   import jnl_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_text_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_number_kind;
   logic signed [63:0] rsp_integer_result;
   logic [15:0]        rsp_number_length;

   number_tracker scanner = new();
   logic [7:0]    text_q[$];
   bit            calm;
   int unsigned   cycle_count = 0;
   int unsigned   sent;

   json_number_lexer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_number_kind    (rsp_number_kind),
      .rsp_integer_result (rsp_integer_result),
      .rsp_number_length  (rsp_number_length)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) scanner.scan_byte(req_text_byte);
         if (rsp_valid && rsp_ready)
            scanner.match_number(rsp_number_kind, rsp_integer_result, rsp_number_length);
      end
   end

   // Result side: stall in bursts, hold ready high when calm.
   initial begin : rsp_pacing
      int unsigned hold;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 9) == 0) begin
            hold = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function void push_str(string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endfunction

   function void push_digits(int n, bit nonzero_first);
      for (int i = 0; i < n; i++) begin
         if (i == 0 && nonzero_first) text_q.push_back(CHAR_ZERO + 8'($urandom_range(1, 9)));
         else text_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      end
   endfunction

   function void push_integer();
      if ($urandom_range(0, 2) == 0) text_q.push_back(CHAR_MINUS);
      if ($urandom_range(0, 5) == 0) text_q.push_back(CHAR_ZERO);
      else push_digits($urandom_range(1, 6), 1'b1);
   endfunction

   function void push_exponent();
      text_q.push_back($urandom_range(0, 1) ? CHAR_EXP_L : CHAR_EXP_U);
      case ($urandom_range(0, 2))
         0: text_q.push_back(CHAR_PLUS);
         1: text_q.push_back(CHAR_MINUS);
         default: ;
      endcase
      push_digits($urandom_range(1, 3), 1'b0);
   endfunction

   // Optional whitespace, one number-like token, then a byte that may or may not end it.
   function void add_token();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3)) begin
         case ($urandom_range(0, 3))
            0: text_q.push_back(CHAR_SPACE);
            1: text_q.push_back(CHAR_TAB);
            2: text_q.push_back(CHAR_LF);
            default: text_q.push_back(CHAR_CR);
         endcase
      end
      if (pick < 25) begin
         push_integer();
      end else if (pick < 37) begin
         case ($urandom_range(0, 9))
            0: push_str("9223372036854775807");
            1: push_str("9223372036854775808");
            2: push_str("-9223372036854775808");
            3: push_str("-9223372036854775809");
            4: push_str("18446744073709551609");
            5: push_str("18446744073709551615");
            6: push_str("18446744073709551616");
            7: push_str("1844674407370955160");
            8: push_str("1844674407370955161");
            default: push_str("-184467440737095516099");
         endcase
      end else if (pick < 47) begin
         if ($urandom_range(0, 1)) text_q.push_back(CHAR_MINUS);
         push_digits($urandom_range(17, 26), 1'b1);
         if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CHAR_POINT);
            push_digits($urandom_range(1, 3), 1'b0);
         end
      end else if (pick < 61) begin
         push_integer();
         text_q.push_back(CHAR_POINT);
         push_digits($urandom_range(1, 5), 1'b0);
         if ($urandom_range(0, 1)) push_exponent();
      end else if (pick < 72) begin
         push_integer();
         push_exponent();
      end else if (pick < 86) begin
         // well-formed prefix, then a byte that may break it
         case ($urandom_range(0, 6))
            0: push_str("-");
            1: push_str("1.");
            2: push_str("0e");
            3: push_str("2E+");
            4: push_str("-0.");
            5: push_str("37e-");
            default: push_str("4.5E");
         endcase
         text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         text_q.push_back(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 9))
         0, 1: text_q.push_back(CHAR_SPACE);
         2: push_str(",");
         3: push_str("]");
         4: push_str("}");
         5: text_q.push_back(CHAR_LF);
         6: text_q.push_back(CHAR_MINUS);
         7: push_digits(1, 1'b0);
         default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text();
      while (text_q.size() != 0) begin
         send_byte(text_q.pop_front());
         sent++;
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_text_byte = '0;
      calm          = 1'b0;
      sent          = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_str(" \t\n\r-0,01 1.5e+3x-.0E9 ");
      text_q.push_back(8'hFF);
      text_q.push_back(8'h00);
      send_text();

      while (sent < 1000) begin
         add_token();
         send_text();
      end

      // no idling from here on; a long negative number, then 30 tokens
      calm = 1'b1;
      push_str(",");
      push_str("-");
      push_digits(40, 1'b1);
      push_str(".5 ");
      repeat (30) add_token();
      push_str(" ");
      send_text();
      req_valid <= 1'b0;

      while (scanner.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (scanner.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
